// ===== rtl/ibrf_pkg.sv =====
// Shared types and codes for the byte ring FIFO core.
// No dependencies; every other file uses this package.
package ibrf_pkg;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_WRITE     = 3'd0;
    localparam t_cmd CMD_READ      = 3'd1;
    localparam t_cmd CMD_SET_OWNER = 3'd2;
    localparam t_cmd CMD_GET_OWNER = 3'd3;
    localparam t_cmd CMD_SET_MODE  = 3'd4;
    localparam t_cmd CMD_CLEAR     = 3'd5;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_READ   = 2'd0;
    localparam t_mode MODE_WRITE  = 2'd1;
    localparam t_mode MODE_RW     = 2'd2;
    localparam t_mode MODE_CLOSED = 2'd3;

    typedef logic [7:0] t_byte;

    // request from the core to the owner table
    typedef struct packed {
        logic  set_en;
        logic  get_en;
        t_byte idx;
        logic  occ;
        t_byte pid;
    } t_own_req;

    // status from the owner table, valid in the request cycle
    typedef struct packed {
        logic hit;
        logic none_left;
    } t_own_sts;

endpackage

// ===== rtl/ibrf_in_if.sv =====
// Request channel of the byte ring FIFO core: valid/ready plus request fields.
// Depends on ibrf_pkg.
interface ibrf_in_if;
    logic              valid;
    logic              ready;
    ibrf_pkg::t_cmd    cmd;
    ibrf_pkg::t_byte   data_byte;
    logic              burst_start;
    logic              bypass_mode;
    ibrf_pkg::t_byte   slot_index;
    ibrf_pkg::t_byte   process_id;
    logic              slot_occupied;
    ibrf_pkg::t_mode   new_mode;

    modport source (
        output valid, cmd, data_byte, burst_start, bypass_mode, slot_index,
               process_id, slot_occupied, new_mode,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_byte, burst_start, bypass_mode, slot_index,
               process_id, slot_occupied, new_mode,
        output ready
    );
endinterface

// ===== rtl/ibrf_out_if.sv =====
// Result channel of the byte ring FIFO core: valid/ready plus result fields.
// Depends on ibrf_pkg; FILL_W must match the core's fill counter width.
interface ibrf_out_if #(parameter int FILL_W = 11);
    logic              valid;
    logic              ready;
    logic              accepted;
    ibrf_pkg::t_byte   read_byte;
    logic [FILL_W-1:0] fill_level;
    ibrf_pkg::t_mode   current_mode;
    logic              owner_present;
    ibrf_pkg::t_byte   owner_id;

    modport source (
        output valid, accepted, read_byte, fill_level, current_mode,
               owner_present, owner_id,
        input  ready
    );
    modport sink (
        input  valid, accepted, read_byte, fill_level, current_mode,
               owner_present, owner_id,
        output ready
    );
endinterface

// ===== rtl/ibrf_byte_ram.sv =====
// Single-write, single-read synchronous byte memory with registered read data.
// Depends on ibrf_pkg for the byte type.
module ibrf_byte_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ibrf_pkg::t_byte          i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ibrf_pkg::t_byte          o_rdata
);
    import ibrf_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ibrf_owner_tbl.sv =====
// Owner slot table: valid flags and occupied count in flops, ids in a memory.
// Depends on ibrf_pkg for the request and status structs.
module ibrf_owner_tbl #(
    parameter int OWNER_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ibrf_pkg::t_own_req  i_req,
    output ibrf_pkg::t_own_sts  o_sts,
    output ibrf_pkg::t_byte     o_id
);
    import ibrf_pkg::*;

    localparam int SLOT_W = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(OWNER_SLOTS + 1);

    logic [OWNER_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    t_byte                  r_ids [OWNER_SLOTS];
    t_byte                  r_id;
    logic                   in_range;
    logic [SLOT_W-1:0]      idx_s;
    logic                   cur_vld;
    logic                   set_go;

    always_comb begin
        in_range = {1'b0, i_req.idx} < 9'(OWNER_SLOTS);
        idx_s    = i_req.idx[SLOT_W-1:0];
        cur_vld  = in_range && r_valid[idx_s];
        set_go   = i_req.set_en && in_range;
        n_cnt    = r_cnt;
        if (set_go) begin
            if (cur_vld && !i_req.occ) begin
                n_cnt = r_cnt - CNT_W'(1);
            end else if (!cur_vld && i_req.occ) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
        o_sts.hit       = cur_vld;
        o_sts.none_left = (n_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
        end else if (set_go) begin
            r_valid[idx_s] <= i_req.occ;
            r_cnt          <= n_cnt;
        end
    end

    // an id is only read back while its slot is valid, so emptying needs no write
    always_ff @(posedge i_clk) begin
        if (set_go && i_req.occ) begin
            r_ids[idx_s] <= i_req.pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.get_en && in_range) begin
            r_id <= r_ids[idx_s];
        end
    end

    assign o_id = r_id;

endmodule

// ===== rtl/ipc_byte_ring_fifo_core.sv =====
// Byte ring FIFO core with access mode and owner slots.
// A result passes through a pending stage and an output register after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the reads of the byte RAM
// and owner id RAM feed a one-entry pending stage ahead of the output register.
// Reset (synchronous, active low) clears pointers, fill, mode, burst flag, owner
// flags and pipe valids; RAM contents are left as is and need no clearing pass.
module ipc_byte_ring_fifo_core #(
    parameter int FIFO_DEPTH  = 1024,
    parameter int OWNER_SLOTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ibrf_in_if.sink       i_req,
    ibrf_out_if.source    o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import ibrf_pkg::*;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_mode             r_mode, n_mode;
    logic              r_burst, n_burst;
    logic              r_is_pipe;

    logic              r_p_vld, r_p_acc, r_p_rd, r_p_get;
    logic [FILL_W-1:0] r_p_fill;
    t_mode             r_p_mode;

    logic              r_o_vld, r_o_acc, r_o_pres;
    t_byte             r_o_rbyte, r_o_oid;
    logic [FILL_W-1:0] r_o_fill;
    t_mode             r_o_mode;

    logic              acc, p_move;
    logic              wr_ok, rd_ok, adm, wr_go, rd_go, get_hit;
    logic [FILL_W:0]   wr_sum;
    logic [PTR_W-1:0]  wr_addr;
    t_byte             ram_q, own_id;
    t_own_req          own_req;
    t_own_sts          own_sts;

    ibrf_byte_ram #(
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (acc && wr_go),
        .i_waddr (wr_addr),
        .i_wdata (i_req.data_byte),
        .i_re    (acc && rd_go),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    ibrf_owner_tbl #(
        .OWNER_SLOTS (OWNER_SLOTS)
    ) u_own (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (own_req),
        .o_sts   (own_sts),
        .o_id    (own_id)
    );

    assign p_move      = r_p_vld && (!r_o_vld || o_rsp.ready);
    assign i_req.ready = !r_p_vld || p_move;
    assign acc         = i_req.valid && i_req.ready;

    always_comb begin
        // write slot wraps once at most: pointer is below depth and fill is at most depth
        wr_sum = {1'b0, FILL_W'(r_rd_ptr)} + {1'b0, r_fill};
        if (wr_sum >= (FILL_W+1)'(FIFO_DEPTH)) begin
            wr_sum = wr_sum - (FILL_W+1)'(FIFO_DEPTH);
        end
        wr_addr = wr_sum[PTR_W-1:0];

        wr_ok = i_req.bypass_mode || r_mode == MODE_WRITE || r_mode == MODE_RW;
        rd_ok = i_req.bypass_mode || r_mode == MODE_READ || r_mode == MODE_RW;
        adm   = i_req.burst_start
              ? (wr_ok && r_fill < FILL_W'(FIFO_DEPTH - 1)) : r_burst;

        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        n_mode   = r_mode;
        n_burst  = r_burst;
        wr_go    = 1'b0;
        rd_go    = 1'b0;
        get_hit  = 1'b0;

        own_req.set_en = acc && i_req.cmd == CMD_SET_OWNER;
        own_req.get_en = acc && i_req.cmd == CMD_GET_OWNER;
        own_req.idx    = i_req.slot_index;
        own_req.occ    = i_req.slot_occupied;
        own_req.pid    = i_req.process_id;

        case (i_req.cmd)
            CMD_WRITE: begin
                n_burst = adm;
                if (adm && wr_ok && r_fill < FILL_W'(FIFO_DEPTH)) begin
                    wr_go  = 1'b1;
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            CMD_READ: begin
                if (rd_ok && r_fill != '0) begin
                    rd_go    = 1'b1;
                    n_fill   = r_fill - FILL_W'(1);
                    n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1))
                             ? '0 : r_rd_ptr + PTR_W'(1);
                end
            end
            CMD_SET_OWNER: begin
                // pipe closes once the last owner leaves
                if (r_is_pipe && own_sts.none_left) begin
                    n_mode = MODE_CLOSED;
                end
            end
            CMD_GET_OWNER: begin
                get_hit = own_sts.hit;
            end
            CMD_SET_MODE: begin
                n_mode = i_req.new_mode;
            end
            CMD_CLEAR: begin
                n_fill   = '0;
                n_rd_ptr = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_fill    <= '0;
            r_mode    <= MODE_READ;
            r_burst   <= 1'b0;
            r_is_pipe <= 1'b0;
            r_p_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_is_pipe <= i_cfg_wdata;
            end
            if (acc) begin
                r_rd_ptr <= n_rd_ptr;
                r_fill   <= n_fill;
                r_mode   <= n_mode;
                r_burst  <= n_burst;
            end
            if (acc) begin
                r_p_vld <= 1'b1;
            end else if (p_move) begin
                r_p_vld <= 1'b0;
            end
            if (p_move) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_acc  <= wr_go || rd_go;
            r_p_rd   <= rd_go;
            r_p_get  <= get_hit;
            r_p_fill <= n_fill;
            r_p_mode <= n_mode;
        end
        // RAM read data holds until the next accepted read
        if (p_move) begin
            r_o_acc   <= r_p_acc;
            r_o_rbyte <= r_p_rd ? ram_q : '0;
            r_o_pres  <= r_p_get;
            r_o_oid   <= r_p_get ? own_id : '0;
            r_o_fill  <= r_p_fill;
            r_o_mode  <= r_p_mode;
        end
    end

    assign o_rsp.valid         = r_o_vld;
    assign o_rsp.accepted      = r_o_acc;
    assign o_rsp.read_byte     = r_o_rbyte;
    assign o_rsp.fill_level    = r_o_fill;
    assign o_rsp.current_mode  = r_o_mode;
    assign o_rsp.owner_present = r_o_pres;
    assign o_rsp.owner_id      = r_o_oid;

endmodule

// ===== rtl/ibrf_chk.sv =====
// Port-level checks for the byte ring FIFO core, bound to the top level.
// Depends on ibrf_pkg and ipc_byte_ring_fifo_core.
module ibrf_chk #(
    parameter int FIFO_DEPTH = 1024,
    parameter int FILL_W     = 11
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_o_valid,
    input logic              i_o_ready,
    input logic              i_o_accepted,
    input ibrf_pkg::t_byte   i_o_read_byte,
    input logic [FILL_W-1:0] i_o_fill_level,
    input logic              i_o_owner_present,
    input ibrf_pkg::t_byte   i_o_owner_id
);
    import ibrf_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid && !i_o_ready |=> i_o_valid && $stable(i_o_fill_level)
            && $stable(i_o_read_byte) && $stable(i_o_owner_id))
        else $error("stalled result changed");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid |-> i_o_fill_level <= FILL_W'(FIFO_DEPTH))
        else $error("fill level above depth");

    a_rbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid && !i_o_accepted |-> i_o_read_byte == '0)
        else $error("read byte set on a refused request");

    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid && !i_o_owner_present |-> i_o_owner_id == '0)
        else $error("owner id set without an owner");

endmodule

bind ipc_byte_ring_fifo_core ibrf_chk #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .FILL_W     (FILL_W)
) u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_o_valid         (o_rsp.valid),
    .i_o_ready         (o_rsp.ready),
    .i_o_accepted      (o_rsp.accepted),
    .i_o_read_byte     (o_rsp.read_byte),
    .i_o_fill_level    (o_rsp.fill_level),
    .i_o_owner_present (o_rsp.owner_present),
    .i_o_owner_id      (o_rsp.owner_id)
);
